FILE: rtl/core/tvbb_pkg.sv
// shared constants, types and register indexes for the transformed vertex bounding box
// no dependencies; imported by every module of the block
`default_nettype none

package tvbb_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int FRACTION_BITS = 8;
    localparam int COEF_WIDTH    = 16;
    localparam int COEFS_PER_ROW = 4;
    localparam int ROW_WIDTH     = COEF_WIDTH * COEFS_PER_ROW;
    localparam int OUT_WIDTH     = 24;
    localparam int AXES          = 3;

    // one product, the shifted translation and the saturation bounds must all fit
    localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
    localparam int TRANS_WIDTH = COEF_WIDTH + FRACTION_BITS;
    localparam int ACC_BASE0   = (PROD_WIDTH > TRANS_WIDTH) ? PROD_WIDTH : TRANS_WIDTH;
    localparam int ACC_BASE    = (ACC_BASE0 > OUT_WIDTH) ? ACC_BASE0 : OUT_WIDTH;
    localparam int ACC_WIDTH   = ACC_BASE + 2;

    localparam int S_DATA_WIDTH = ((AXES * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_FIELDS     = 4 * AXES;
    localparam int M_DATA_WIDTH = ((M_FIELDS * OUT_WIDTH + 7) / 8) * 8;

    localparam int CFG_INDEX_WIDTH = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Z = 2'd2;

    // identity matrix in Q8.8
    localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [OUT_WIDTH-1:0]   world_t;
    typedef logic [ROW_WIDTH-1:0]          row_t;

    // transformed vertex handed from the transform pipeline to the box stage
    typedef struct packed {
        logic   valid;
        logic   last;
        world_t wx;
        world_t wy;
        world_t wz;
    } world_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/tvbb_xform.sv
// affine transform pipeline: registered products, then sum, floor shift and saturation
// depends on tvbb_pkg
`default_nettype none

module tvbb_xform (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           adv,
    input  wire                           in_valid,
    input  wire                           in_last,
    input  tvbb_pkg::coord_t [2:0]        vtx,
    input  tvbb_pkg::row_t   [2:0]        rows,
    output tvbb_pkg::world_req_t          wq
);
    import tvbb_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] SAT_HI = ACC_WIDTH'((2 ** (OUT_WIDTH - 1)) - 1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(1);

    logic                           prod_valid_reg;
    logic                           prod_last_reg;
    logic signed [PROD_WIDTH-1:0]   prod_reg  [AXES][AXES];
    logic signed [COEF_WIDTH-1:0]   trans_reg [AXES];

    logic                           world_valid_reg;
    logic                           world_last_reg;
    world_t                         world_reg  [AXES];
    world_t                         world_next [AXES];

    logic signed [ACC_WIDTH-1:0]    acc     [AXES];
    logic signed [ACC_WIDTH-1:0]    acc_flr [AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg  <= 1'b0;
            prod_last_reg   <= 1'b0;
            world_valid_reg <= 1'b0;
            world_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg  <= in_valid;
            prod_last_reg   <= in_last;
            world_valid_reg <= prod_valid_reg;
            world_last_reg  <= prod_last_reg;
        end
    end

    // nine 16x16 products, one per row and vertex coordinate
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                for (int c = 0; c < AXES; c++)
                begin
                    prod_reg[r][c] <= $signed(rows[r][COEF_WIDTH*c +: COEF_WIDTH])
                                      * $signed(vtx[c]);
                end
                trans_reg[r] <= $signed(rows[r][COEF_WIDTH*AXES +: COEF_WIDTH]);
            end
            for (int r = 0; r < AXES; r++)
            begin
                world_reg[r] <= world_next[r];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < AXES; r++)
        begin
            acc[r] = ACC_WIDTH'(prod_reg[r][0]) + ACC_WIDTH'(prod_reg[r][1])
                   + ACC_WIDTH'(prod_reg[r][2])
                   + (ACC_WIDTH'(trans_reg[r]) <<< FRACTION_BITS);
            // arithmetic shift rounds toward minus infinity
            acc_flr[r] = acc[r] >>> FRACTION_BITS;
            if (acc_flr[r] > SAT_HI)
            begin
                world_next[r] = SAT_HI[OUT_WIDTH-1:0];
            end
            else if (acc_flr[r] < SAT_LO)
            begin
                world_next[r] = SAT_LO[OUT_WIDTH-1:0];
            end
            else
            begin
                world_next[r] = acc_flr[r][OUT_WIDTH-1:0];
            end
        end
    end

    assign wq.valid = world_valid_reg;
    assign wq.last  = world_last_reg;
    assign wq.wx    = world_reg[0];
    assign wq.wy    = world_reg[1];
    assign wq.wz    = world_reg[2];

endmodule

`default_nettype wire

FILE: rtl/core/tvbb_box.sv
// per-axis min/max accumulation, result register and output register with center and extent
// depends on tvbb_pkg
`default_nettype none

module tvbb_box (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  tvbb_pkg::world_req_t                  wq,
    input  wire                                   m_tready,
    output logic                                  adv,
    output logic                                  m_tvalid,
    output logic [tvbb_pkg::M_DATA_WIDTH-1:0]     m_tdata
);
    import tvbb_pkg::*;

    logic   open_reg;
    world_t lo_reg [AXES];
    world_t hi_reg [AXES];
    world_t w      [AXES];
    world_t lo_next [AXES];
    world_t hi_next [AXES];

    logic   res_valid_reg;
    world_t res_lo_reg [AXES];
    world_t res_hi_reg [AXES];

    logic                       out_valid_reg;
    logic [M_DATA_WIDTH-1:0]    out_data_reg;
    logic [M_DATA_WIDTH-1:0]    out_data_next;
    logic signed [OUT_WIDTH:0]  mid_sum [AXES];
    logic                       take;
    logic                       hold;

    assign w[0] = wq.wx;
    assign w[1] = wq.wy;
    assign w[2] = wq.wz;

    // stall only when a finished box waits behind an output that is still held
    assign hold = res_valid_reg && out_valid_reg && !m_tready;
    assign adv  = !hold;
    assign take = adv && wq.valid;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            lo_next[a] = lo_reg[a];
            hi_next[a] = hi_reg[a];
            if (!open_reg)
            begin
                lo_next[a] = w[a];
                hi_next[a] = w[a];
            end
            else if (w[a] < lo_reg[a])
            begin
                lo_next[a] = w[a];
            end
            else if (w[a] > hi_reg[a])
            begin
                hi_next[a] = w[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                lo_reg[a] <= '0;
                hi_reg[a] <= '0;
            end
        end
        else if (take)
        begin
            open_reg <= !wq.last;
            for (int a = 0; a < AXES; a++)
            begin
                lo_reg[a] <= lo_next[a];
                hi_reg[a] <= hi_next[a];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                res_valid_reg <= wq.valid && wq.last;
            end
            if (adv && res_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_data_next = '0;
        for (int a = 0; a < AXES; a++)
        begin
            mid_sum[a] = (OUT_WIDTH+1)'(res_lo_reg[a]) + (OUT_WIDTH+1)'(res_hi_reg[a]);
            out_data_next[OUT_WIDTH*a +: OUT_WIDTH]          = res_lo_reg[a];
            out_data_next[OUT_WIDTH*(a+AXES) +: OUT_WIDTH]   = res_hi_reg[a];
            out_data_next[OUT_WIDTH*(a+2*AXES) +: OUT_WIDTH] = mid_sum[a][OUT_WIDTH:1];
            out_data_next[OUT_WIDTH*(a+3*AXES) +: OUT_WIDTH] =
                OUT_WIDTH'(res_hi_reg[a] - res_lo_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && wq.valid && wq.last)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                res_lo_reg[a] <= lo_next[a];
                res_hi_reg[a] <= hi_next[a];
            end
        end
        if (adv && res_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // an open box never has min above max
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (lo_reg[0] <= hi_reg[0]) && (lo_reg[1] <= hi_reg[1])
                     && (lo_reg[2] <= hi_reg[2]))
        else $error("box min above max");

    // a finished box waiting behind a stalled output is kept
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> res_valid_reg && $stable(res_lo_reg[0]) && $stable(res_hi_reg[0]))
        else $error("pending box lost while output stalled");

    // a last vertex always closes the box
    a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && wq.last) |=> !open_reg && res_valid_reg)
        else $error("last vertex did not close box");

    // the result register only moves into an output slot that is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && adv) |-> (!out_valid_reg || m_tready))
        else $error("result would overwrite held output");

endmodule

`default_nettype wire

FILE: rtl/core/transformed_vertex_bounding_box.sv
// Transformed vertex bounding box, top level: configuration rows, input register, pipeline.
// Depends on tvbb_pkg, tvbb_xform and tvbb_box.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tlast carry vertex requests (x, y, z in signed Q8.8);
//   s_tlast marks the last vertex of a mesh. Every vertex is mapped through the
//   3x4 affine matrix held in the cfg rows and folded into a per-axis min/max box.
//   On each last vertex one request leaves on m_tvalid/m_tready/m_tdata with
//   min, max, center and extent per axis, all 24-bit Q16.8; the box then reopens.
//   cfg_we/cfg_index/cfg_data write a matrix row (index 0..2); other indexes are ignored.
//   Rows must be written only while no vertex is in flight; the block does not enforce it.
// Timing:
//   one vertex per cycle sustained while s_tready is high. After the last vertex is
//   accepted (the input register loads on the accepting edge), its box moves through the
//   product, transform and box result registers to the output register on m_tvalid.
// Reset:
//   matrix returns to identity, the box is closed, all stages empty.
// Stall:
//   while m_tready is low the pipeline keeps moving; s_tready drops only when a
//   second finished box is waiting behind the held output.
`default_nettype none

module transformed_vertex_bounding_box (
    input  wire                                       clk,
    input  wire                                       rst_n,
    input  wire                                       s_tvalid,
    output logic                                      s_tready,
    input  wire  [tvbb_pkg::S_DATA_WIDTH-1:0]         s_tdata,   // vertex_x, vertex_y, vertex_z
    input  wire                                       s_tlast,   // last_vertex
    output logic                                      m_tvalid,
    input  wire                                       m_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z,
    // center_x, center_y, center_z, extent_x, extent_y, extent_z
    output logic [tvbb_pkg::M_DATA_WIDTH-1:0]         m_tdata,
    input  wire                                       cfg_we,
    input  wire  [tvbb_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  wire  [tvbb_pkg::ROW_WIDTH-1:0]            cfg_data
);
    import tvbb_pkg::*;

    row_t   [2:0]   rows_reg;
    logic           in_valid_reg;
    logic           in_last_reg;
    coord_t [2:0]   vtx_reg;
    logic           adv;
    world_req_t     wq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[0] <= ROW_X_RESET;
            rows_reg[1] <= ROW_Y_RESET;
            rows_reg[2] <= ROW_Z_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_X: rows_reg[0] <= cfg_data;
                REG_ROW_Y: rows_reg[1] <= cfg_data;
                REG_ROW_Z: rows_reg[2] <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= s_tvalid;
            in_last_reg  <= s_tlast;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                vtx_reg[a] <= s_tdata[COORD_WIDTH*a +: COORD_WIDTH];
            end
        end
    end

    assign s_tready = adv;

    tvbb_xform u_xform (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid_reg),
        .in_last  (in_last_reg),
        .vtx      (vtx_reg),
        .rows     (rows_reg),
        .wq       (wq)
    );

    tvbb_box u_box (
        .clk      (clk),
        .rst_n    (rst_n),
        .wq       (wq),
        .m_tready (m_tready),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: test/tb_transformed_vertex_bounding_box.sv
// self-checking testbench for transformed_vertex_bounding_box: vertex stream in, box results out
// depends on tvbb_pkg and the block's rtl; a tracker class predicts every box from the matrix rows
`timescale 1ns / 1ps

module tb_transformed_vertex_bounding_box;

    import tvbb_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     PHASE_ITEMS  = 70;
    localparam longint OUT_HIGH     = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
    localparam longint OUT_LOW      = -OUT_HIGH - 1;

    // index with no register behind it
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    localparam row_t ROW_SAT_POS = 64'h7FFF_7FFF_7FFF_7FFF;
    localparam row_t ROW_SAT_NEG = 64'h8000_8000_8000_8000;

    class box_tracker;
        row_t                    rows[AXES];
        world_t                  lo[AXES];
        world_t                  hi[AXES];
        bit                      box_open;
        logic [M_DATA_WIDTH-1:0] expected_boxes[$];
        int                      mismatches;
        string                   field_names[M_FIELDS];

        function new();
            rows[0]     = ROW_X_RESET;
            rows[1]     = ROW_Y_RESET;
            rows[2]     = ROW_Z_RESET;
            box_open    = 1'b0;
            mismatches  = 0;
            field_names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z",
                            "center_x", "center_y", "center_z",
                            "extent_x", "extent_y", "extent_z"};
            for (int a = 0; a < AXES; a++)
            begin
                lo[a] = '0;
                hi[a] = '0;
            end
        endfunction

        function void write_row(logic [CFG_INDEX_WIDTH-1:0] idx, row_t value);
            case (idx)
                REG_ROW_X: rows[0] = value;
                REG_ROW_Y: rows[1] = value;
                REG_ROW_Z: rows[2] = value;
                default:   ;
            endcase
        endfunction

        // affine row times vertex, floored to the output fraction and clamped to 24 bits
        function world_t world_coord(row_t r, coord_t v[AXES]);
            longint acc;
            acc = longint'($signed(r[ROW_WIDTH-COEF_WIDTH +: COEF_WIDTH]))
                  * (longint'(1) <<< FRACTION_BITS);
            for (int k = 0; k < AXES; k++)
                acc += longint'($signed(r[k*COEF_WIDTH +: COEF_WIDTH])) * longint'(v[k]);
            acc = acc >>> FRACTION_BITS;
            if (acc > OUT_HIGH)
                acc = OUT_HIGH;
            if (acc < OUT_LOW)
                acc = OUT_LOW;
            return world_t'(acc);
        endfunction

        function void note_vertex(coord_t x, coord_t y, coord_t z, bit last);
            coord_t                  v[AXES];
            world_t                  w;
            longint                  sum;
            logic [M_DATA_WIDTH-1:0] box;
            v[0] = x;
            v[1] = y;
            v[2] = z;
            for (int a = 0; a < AXES; a++)
            begin
                w = world_coord(rows[a], v);
                if (!box_open)
                begin
                    lo[a] = w;
                    hi[a] = w;
                end
                else if (w < lo[a])
                    lo[a] = w;
                else if (w > hi[a])
                    hi[a] = w;
            end
            box_open = 1'b1;
            if (last)
            begin
                box = '0;
                for (int a = 0; a < AXES; a++)
                begin
                    sum = longint'(lo[a]) + longint'(hi[a]);
                    box[a*OUT_WIDTH +: OUT_WIDTH]        = lo[a];
                    box[(a+3)*OUT_WIDTH +: OUT_WIDTH]    = hi[a];
                    box[(a+6)*OUT_WIDTH +: OUT_WIDTH]    = world_t'(sum >>> 1);
                    box[(a+9)*OUT_WIDTH +: OUT_WIDTH]    =
                        world_t'(longint'(hi[a]) - longint'(lo[a]));
                end
                expected_boxes.push_back(box);
                box_open = 1'b0;
            end
        endfunction

        function void check_box(logic [M_DATA_WIDTH-1:0] got);
            logic [M_DATA_WIDTH-1:0] want;
            if (expected_boxes.size() == 0)
            begin
                $error("box result with none pending: 0x%h", got);
                mismatches++;
            end
            else
            begin
                want = expected_boxes.pop_front();
                for (int i = 0; i < M_FIELDS; i++)
                    if (got[i*OUT_WIDTH +: OUT_WIDTH] !== want[i*OUT_WIDTH +: OUT_WIDTH])
                    begin
                        $error("%s: expected 0x%06h, got 0x%06h", field_names[i],
                               want[i*OUT_WIDTH +: OUT_WIDTH], got[i*OUT_WIDTH +: OUT_WIDTH]);
                        mismatches++;
                    end
            end
        endfunction

        function int pending();
            return expected_boxes.size();
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [S_DATA_WIDTH-1:0]    s_tdata   = '0;
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [M_DATA_WIDTH-1:0]    m_tdata;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [ROW_WIDTH-1:0]       cfg_data  = '0;

    bit         src_idle  = 1'b1;
    bit         sink_idle = 1'b1;
    int         cycle_count = 0;
    box_tracker boxes = new();

    transformed_vertex_bounding_box u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // vertex_x, vertex_y, vertex_z
        .s_tlast   (s_tlast),   // last_vertex
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // min_x, min_y, min_z, max_x, max_y, max_z,
        // center_x, center_y, center_z, extent_x, extent_y, extent_z
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_vertex(coord_t x, coord_t y, coord_t z, bit last);
        int gap;
        gap = src_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        boxes.note_vertex(x, y, z, last);
    endtask

    // stop sending, collect every pending box and let the pipeline empty
    task automatic end_phase();
        s_tvalid <= 1'b0;
        while (boxes.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_matrix(row_t rx, row_t ry, row_t rz, bit poke_unused);
        row_t junk;
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROW_X;
        cfg_data  <= rx;
        @(posedge clk);
        boxes.write_row(REG_ROW_X, rx);
        cfg_index <= REG_ROW_Y;
        cfg_data  <= ry;
        @(posedge clk);
        boxes.write_row(REG_ROW_Y, ry);
        cfg_index <= REG_ROW_Z;
        cfg_data  <= rz;
        @(posedge clk);
        boxes.write_row(REG_ROW_Z, rz);
        if (poke_unused)
        begin
            junk      = {$urandom, $urandom};
            cfg_index <= REG_UNUSED;
            cfg_data  <= junk;
            @(posedge clk);
            boxes.write_row(REG_UNUSED, junk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return coord_t'(-32768);
            1:       return coord_t'(32767);
            2:       return coord_t'(0);
            3:       return coord_t'(-1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // coefficients within +-2.0, any translation
    function automatic row_t small_row();
        row_t r;
        int   c;
        for (int k = 0; k < AXES; k++)
        begin
            c = int'($urandom_range(0, 1024)) - 512;
            r[k*COEF_WIDTH +: COEF_WIDTH] = c[COEF_WIDTH-1:0];
        end
        r[ROW_WIDTH-COEF_WIDTH +: COEF_WIDTH] = COEF_WIDTH'($urandom);
        return r;
    endfunction

    task automatic send_random_set(int n);
        coord_t px, py, pz;
        for (int i = 0; i < n; i++)
        begin
            // now and then repeat the previous vertex to hit min/max ties
            if (i == 0 || $urandom_range(0, 3) != 0)
            begin
                px = pick_coord();
                py = pick_coord();
                pz = pick_coord();
            end
            send_vertex(px, py, pz, i == n - 1);
        end
    endtask

    initial
    begin
        int   m_stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_stall = sink_idle ? $urandom_range(0, 5) : 0;
            if (m_stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (m_stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            boxes.check_box(m_tdata);
        end
    end

    initial
    begin
        int items;
        int n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity after reset: single-vertex sets at zero and the extremes, then a set with ties
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
        send_vertex(coord_t'(32767), coord_t'(32767), coord_t'(32767), 1'b1);
        send_vertex(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 1'b1);
        send_vertex(coord_t'(-32768), coord_t'(32767), coord_t'(0), 1'b0);
        send_vertex(coord_t'(32767), coord_t'(-32768), coord_t'(-1), 1'b0);
        send_vertex(coord_t'(-32768), coord_t'(32767), coord_t'(0), 1'b0);
        send_vertex(coord_t'(100), coord_t'(-100), coord_t'(5), 1'b1);
        end_phase();

        // full-scale coefficients drive every axis into saturation both ways
        set_matrix(ROW_SAT_POS, ROW_SAT_POS, ROW_SAT_POS, 1'b0);
        send_vertex(coord_t'(32767), coord_t'(32767), coord_t'(32767), 1'b0);
        send_vertex(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 1'b0);
        send_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
        end_phase();

        set_matrix(ROW_SAT_NEG, ROW_SAT_NEG, ROW_SAT_NEG, 1'b1);
        send_vertex(coord_t'(32767), coord_t'(32767), coord_t'(32767), 1'b0);
        send_vertex(coord_t'(-32768), coord_t'(-32768), coord_t'(-32768), 1'b0);
        send_vertex(coord_t'(1), coord_t'(1), coord_t'(1), 1'b1);
        end_phase();

        // tiny negative sums must floor, not truncate toward zero
        set_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_0000,
                   64'hFFFF_0080_0000_0000, 1'b1);
        send_vertex(coord_t'(-1), coord_t'(1), coord_t'(1), 1'b0);
        send_vertex(coord_t'(1), coord_t'(-1), coord_t'(-1), 1'b1);
        send_vertex(coord_t'(-255), coord_t'(3), coord_t'(-3), 1'b1);
        end_phase();

        for (int p = 0; p < 6; p++)
        begin
            src_idle  = (p != 1 && p != 3);
            sink_idle = (p != 2 && p != 3);
            case (p % 3)
                0:       set_matrix({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, 1'($urandom_range(0, 1)));
                1:       set_matrix(small_row(), small_row(), small_row(),
                                    1'($urandom_range(0, 1)));
                default: set_matrix(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET,
                                    1'($urandom_range(0, 1)));
            endcase
            items = 0;
            while (items < PHASE_ITEMS)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
                send_random_set(n);
                items += n;
            end
            end_phase();
        end

        if (boxes.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tvbb_pkg.sv
rtl/core/tvbb_xform.sv
rtl/core/tvbb_box.sv
rtl/core/transformed_vertex_bounding_box.sv
test/tb_transformed_vertex_bounding_box.sv
